// ----- design/srim_pkg.sv -----
// Shared types and constants for the ring index manager.
`default_nettype none

package srim_pkg;

  // Default ring capacity in slots.
  localparam int MAX_SLOTS_DEF = 4096;

  // Widths of the external fields.
  localparam int ACTION_W   = 4;
  localparam int AMOUNT_W   = 16;
  localparam int CFG_W      = 13;
  localparam int POSITION_W = 12;
  localparam int COUNT_W    = 13;

  // Action codes: producer actions start at zero, consumer actions repeat them.
  localparam logic [ACTION_W-1:0] ACT_CONS_BASE = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_LAST      = 4'd9;

  typedef enum logic [2:0] {
    OP_ALLOC        = 3'd0,
    OP_ALLOC_NOWRAP = 3'd1,
    OP_COMMIT       = 3'd2,
    OP_WAIT         = 3'd3,
    OP_ABORT        = 3'd4
  } op_t;

  // One result beat, last field in the lowest bits.
  typedef struct packed {
    logic                  consumer_notify;
    logic                  producer_notify;
    logic                  status;
    logic [COUNT_W-1:0]    count;
    logic [POSITION_W-1:0] position;
  } srim_res_t;

endpackage

`default_nettype wire

// ----- design/srim_cfg.sv -----
// Ring size register with range clamping and a clear pulse on each write.
`default_nettype none

module srim_cfg #(
  parameter int MAX_SLOTS = srim_pkg::MAX_SLOTS_DEF,
  parameter int LVL_W     = $clog2(MAX_SLOTS + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [srim_pkg::CFG_W-1:0] wr_data,
  output logic      [LVL_W-1:0]           ring_size,
  output logic                            clear
);

  localparam int CW = (LVL_W > srim_pkg::CFG_W) ? LVL_W : srim_pkg::CFG_W;

  logic [CW-1:0]    wr_wide;
  logic [LVL_W-1:0] ring_size_next;

  // Zero is taken as one slot and anything above capacity as full capacity.
  always_comb begin
    wr_wide = CW'(wr_data);
    if (wr_wide == '0) begin
      ring_size_next = LVL_W'(1);
    end else if (wr_wide > CW'(MAX_SLOTS)) begin
      ring_size_next = LVL_W'(MAX_SLOTS);
    end else begin
      ring_size_next = wr_wide[LVL_W-1:0];
    end
  end

  // The ring state is cleared at the same edge that loads the new size.
  assign clear = wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= LVL_W'(MAX_SLOTS);
    end else if (wr_en) begin
      ring_size <= ring_size_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/srim_core.sv -----
// Index, fill level and wait state of the ring, with the per-action update logic.
`default_nettype none

module srim_core #(
  parameter int MAX_SLOTS = srim_pkg::MAX_SLOTS_DEF,
  parameter int LVL_W     = $clog2(MAX_SLOTS + 1),
  parameter int IDX_W     = $clog2(MAX_SLOTS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire logic                          fire,
  input  wire logic [LVL_W-1:0]              ring_size,
  input  wire logic [srim_pkg::ACTION_W-1:0] action,
  input  wire logic [srim_pkg::AMOUNT_W-1:0] amount,
  input  wire logic                          callback_present,
  output srim_pkg::srim_res_t                res
);

  localparam int CW = (LVL_W > srim_pkg::AMOUNT_W) ? LVL_W : srim_pkg::AMOUNT_W;

  logic [IDX_W-1:0] producer_index, producer_index_next;
  logic [IDX_W-1:0] consumer_index, consumer_index_next;
  logic [LVL_W-1:0] fill_level, fill_level_next;
  logic [LVL_W-1:0] producer_wait, producer_wait_next;
  logic [LVL_W-1:0] consumer_wait, consumer_wait_next;
  logic             producer_has_callback, producer_has_callback_next;
  logic             consumer_has_callback, consumer_has_callback_next;

  logic                          cons;
  logic                          known;
  logic [srim_pkg::ACTION_W-1:0] op_full;
  srim_pkg::op_t                 op;
  logic [IDX_W-1:0]              idx_cur;
  logic [IDX_W-1:0]              idx_commit;
  logic [IDX_W-1:0]              idx_pos;
  logic [LVL_W-1:0]              idx_lvl;
  logic [LVL_W-1:0]              space;
  logic [LVL_W-1:0]              grant;
  logic [LVL_W-1:0]              room;
  logic [LVL_W-1:0]              grant_nowrap;
  logic [LVL_W:0]                sum;
  logic [LVL_W:0]                wrapped;
  logic [LVL_W-1:0]              fill_dec;
  logic [LVL_W-1:0]              fill_inc;
  logic [LVL_W-1:0]              threshold;
  logic [LVL_W-1:0]              side_wait;
  logic [CW-1:0]                 amount_w;
  logic [LVL_W-1:0]              cnt;
  logic                          status;
  logic                          pnote;
  logic                          cnote;
  logic [31:0]                   pos_ext;
  logic [31:0]                   cnt_ext;

  // Shared datapath: the acting side is selected first, then one grant,
  // one wrap add and one threshold compare serve the alloc, commit and wait actions of both sides.
  always_comb begin
    cons      = (action >= srim_pkg::ACT_CONS_BASE);
    known     = (action <= srim_pkg::ACT_LAST);
    op_full   = cons ? (action - srim_pkg::ACT_CONS_BASE) : action;
    op        = srim_pkg::op_t'(op_full[2:0]);
    idx_cur   = cons ? consumer_index : producer_index;
    idx_lvl   = LVL_W'(idx_cur);
    space     = cons ? fill_level : (ring_size - fill_level);
    amount_w  = CW'(amount);
    grant     = (amount_w < CW'(space)) ? LVL_W'(amount) : space;
    room      = ring_size - idx_lvl;
    grant_nowrap = (grant < room) ? grant : room;
    sum       = {1'b0, idx_lvl} + {1'b0, grant};
    wrapped   = (sum >= {1'b0, ring_size}) ? (sum - {1'b0, ring_size}) : sum;
    idx_commit = IDX_W'(wrapped);
    fill_dec  = fill_level - grant;
    fill_inc  = fill_level + grant;
    threshold = (amount_w < CW'(ring_size)) ? LVL_W'(amount) : ring_size;
    side_wait = cons ? consumer_wait : producer_wait;
  end

  always_comb begin
    producer_index_next        = producer_index;
    consumer_index_next        = consumer_index;
    fill_level_next            = fill_level;
    producer_wait_next         = producer_wait;
    consumer_wait_next         = consumer_wait;
    producer_has_callback_next = producer_has_callback;
    consumer_has_callback_next = consumer_has_callback;
    idx_pos = idx_cur;
    cnt     = '0;
    status  = 1'b0;
    pnote   = 1'b0;
    cnote   = 1'b0;
    if (known) begin
      unique case (op)
        srim_pkg::OP_ALLOC: begin
          cnt = grant;
        end
        srim_pkg::OP_ALLOC_NOWRAP: begin
          cnt = grant_nowrap;
        end
        srim_pkg::OP_COMMIT: begin
          cnt     = grant;
          idx_pos = idx_commit;
          if (cons) begin
            consumer_index_next = idx_commit;
            fill_level_next     = fill_dec;
            if (producer_wait != '0 && producer_wait <= (ring_size - fill_dec)) begin
              producer_wait_next = '0;
              pnote              = producer_has_callback;
            end
          end else begin
            producer_index_next = idx_commit;
            fill_level_next     = fill_inc;
            if (consumer_wait != '0 && consumer_wait <= fill_inc) begin
              consumer_wait_next = '0;
              cnote              = consumer_has_callback;
            end
          end
        end
        srim_pkg::OP_WAIT: begin
          // A new wait replaces the old one; a met threshold is not stored.
          status = (threshold > space);
          if (cons) begin
            consumer_has_callback_next = callback_present;
            consumer_wait_next         = status ? threshold : '0;
          end else begin
            producer_has_callback_next = callback_present;
            producer_wait_next         = status ? threshold : '0;
          end
        end
        srim_pkg::OP_ABORT: begin
          status = (side_wait != '0);
          if (cons) begin
            consumer_wait_next = '0;
          end else begin
            producer_wait_next = '0;
          end
        end
        default: begin
          cnt = '0;
        end
      endcase
    end
    pos_ext = 32'(idx_pos);
    cnt_ext = 32'(cnt);
    res.position        = known ? pos_ext[srim_pkg::POSITION_W-1:0] : '0;
    res.count           = cnt_ext[srim_pkg::COUNT_W-1:0];
    res.status          = status;
    res.producer_notify = pnote;
    res.consumer_notify = cnote;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      producer_index        <= '0;
      consumer_index        <= '0;
      fill_level            <= '0;
      producer_wait         <= '0;
      consumer_wait         <= '0;
      producer_has_callback <= 1'b0;
      consumer_has_callback <= 1'b0;
    end else if (fire) begin
      producer_index        <= producer_index_next;
      consumer_index        <= consumer_index_next;
      fill_level            <= fill_level_next;
      producer_wait         <= producer_wait_next;
      consumer_wait         <= consumer_wait_next;
      producer_has_callback <= producer_has_callback_next;
      consumer_has_callback <= consumer_has_callback_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/spsc_ring_index_manager_top.sv -----
// Top level of the ring index manager: stream ports, input and result registers.
//
// The block tracks the producer index, the consumer index and the fill level
// of a ring buffer whose size is set through the configuration channel.
// Each beat on the s_ channel carries one action (alloc, no-wrap alloc,
// commit, wait or abort, for either side) and produces exactly one result
// beat on the m_ channel: the acting side's index, the granted or committed
// slot count, a status bit and the two notify flags.
// An accepted beat is held in an input register, goes through one level of
// update logic and is registered in the result register, which drives
// m_tvalid. The state update happens in the same cycle the beat moves into
// the result register, so back-to-back beats see each other's effect and one
// beat is accepted every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more beat; after that s_tready drops until the
// result is taken.
// Reset clears all indexes, the fill level and both waits, and sets the ring
// size to MAX_SLOTS. A configuration write also clears all ring state; the user
// must only issue it while no beat is in flight; the block does not enforce this.
`default_nettype none

module spsc_ring_index_manager_top #(
  parameter int MAX_SLOTS = srim_pkg::MAX_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Ring size write: cfg_data holds ring_size.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data,
  // Action beats.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // amount [15:0], callback_present [16], zero fill
  input  wire logic [3:0]  s_tuser,   // action [3:0]
  // Result beats.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // position [11:0], count [24:12], status [25],
                                      // producer_notify [26], consumer_notify [27], zero fill
);

  localparam int LVL_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W = $clog2(MAX_SLOTS);

  logic                          in_valid;
  logic [srim_pkg::ACTION_W-1:0] in_action;
  logic [srim_pkg::AMOUNT_W-1:0] in_amount;
  logic                          in_callback;
  logic                          res_valid;
  srim_pkg::srim_res_t           res;
  srim_pkg::srim_res_t           res_next;
  logic                          advance;
  logic                          s_accept;
  logic                          cfg_we;
  logic [LVL_W-1:0]              ring_size;
  logic                          ring_clear;

  // The configuration register is always ready for a write.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // A beat moves from the input register into the result register whenever
  // the result register is empty or being drained this cycle.
  assign advance  = in_valid && (!res_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_action   <= s_tuser;
      in_amount   <= s_tdata[15:0];
      in_callback <= s_tdata[16];
    end
  end

  srim_cfg #(
    .MAX_SLOTS (MAX_SLOTS),
    .LVL_W     (LVL_W)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_we),
    .wr_data   (cfg_data),
    .ring_size (ring_size),
    .clear     (ring_clear)
  );

  srim_core #(
    .MAX_SLOTS (MAX_SLOTS),
    .LVL_W     (LVL_W),
    .IDX_W     (IDX_W)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .clear            (ring_clear),
    .fire             (advance),
    .ring_size        (ring_size),
    .action           (in_action),
    .amount           (in_amount),
    .callback_present (in_callback),
    .res              (res_next)
  );

  // Result register: holds its beat while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {4'b0000, res};

`ifndef SYNTHESIS
  // A beat that leaves the input register always shows up as a result.
  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("result register not loaded after advance");

  // A held input beat is never dropped while the result side is stalled.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("input beat lost while stalled");

  // Only one side can be notified, by a commit of the other side.
  a_one_notify: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.producer_notify && res.consumer_notify))
    else $error("both notify flags set");

  // A notify is only possible when slots actually moved.
  a_notify_moves: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.producer_notify || res.consumer_notify)) |-> (res.count != '0))
    else $error("notify without committed slots");
`endif

endmodule

`default_nettype wire
